>>> design/ids_pkg.sv
// Shared types and constants of the inertial delay scheduler.
`default_nettype none
package ids_pkg;

	// Width of the driven four-state signal (1 to 64); ports stay 32 bits.
	localparam int WIDTH = 32;
	// Bits actually held: the ports carry at most 32 of them.
	localparam int VW = (WIDTH < 32) ? WIDTH : 32;

	localparam int TW = 32;   // time and delay width
	localparam int IW = 2;    // configuration index width

	localparam logic [IW-1:0] REG_RISE    = 2'd0;
	localparam logic [IW-1:0] REG_FALL    = 2'd1;
	localparam logic [IW-1:0] REG_TURNOFF = 2'd2;

	typedef struct packed {
		logic [VW-1:0] bits;
		logic [VW-1:0] x;
		logic [VW-1:0] z;
	} fsv_t;

	typedef struct packed {
		logic          mode;
		logic [TW-1:0] now;
		fsv_t          value;
		logic          use_mask;
		logic [VW-1:0] mask;
	} item_t;

	typedef struct packed {
		fsv_t          cur;
		fsv_t          pend;
		logic [VW-1:0] pend_mask;
		logic          pend_has_mask;
		logic [TW-1:0] pend_time;
		logic          pend_valid;
	} state_t;

	typedef struct packed {
		logic [TW-1:0] rise;
		logic [TW-1:0] fall;
		logic [TW-1:0] turnoff;
		logic [TW-1:0] min_rf;
		logic [TW-1:0] min_rt;
		logic [TW-1:0] min_ft;
		logic [TW-1:0] min_all;
	} delay_t;

	typedef struct packed {
		logic          commit;
		fsv_t          value;
		logic          pending;
		logic [TW-1:0] due;
		logic          ovf;
	} result_t;

	localparam logic MODE_ASSIGN = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	function automatic logic same_under(fsv_t a, fsv_t b, logic [VW-1:0] m);
		return (((a.bits ^ b.bits) | (a.x ^ b.x) | (a.z ^ b.z)) & m) == '0;
	endfunction

endpackage
`default_nettype wire

>>> design/ids_eval.sv
// Next-state and result logic for one assign or tick word.
`default_nettype none
module ids_eval
	import ids_pkg::*;
(
	input  item_t   item,
	input  state_t  state,
	input  delay_t  dly,
	output state_t  state_nx,
	output result_t res
);

	fsv_t          nv;
	logic [VW-1:0] m;
	logic [VW-1:0] diff;
	logic [VW-1:0] n0;
	logic [VW-1:0] cm;
	logic          ur, uf, ut, ux;
	logic          pend_keep;
	logic [TW-1:0] ticks;
	logic [TW:0]   due;
	logic          ovf;

	always_comb begin
		// Canonicalize: X wins over Z, Z over the value plane.
		nv.x    = item.value.x;
		nv.z    = item.value.z & ~nv.x;
		nv.bits = item.value.bits & ~nv.x & ~nv.z;
		m       = item.use_mask ? item.mask : '1;

		pend_keep = state.pend_valid && (state.pend_has_mask == item.use_mask) &&
			(!item.use_mask || state.pend_mask == m) && same_under(state.pend, nv, m);

		diff = m & ((state.cur.bits ^ nv.bits) | (state.cur.x ^ nv.x) |
			(state.cur.z ^ nv.z));
		n0 = ~nv.bits & ~nv.x & ~nv.z;
		ur = |(diff & nv.bits);
		uf = |(diff & n0);
		ut = |(diff & nv.z);
		ux = |(diff & nv.x);

		// Pick the least delay from the pre-reduced pairs.
		if (ux || (ur && uf && ut)) begin
			ticks = dly.min_all;
		end else if (ur && uf) begin
			ticks = dly.min_rf;
		end else if (ur && ut) begin
			ticks = dly.min_rt;
		end else if (uf && ut) begin
			ticks = dly.min_ft;
		end else if (ur) begin
			ticks = dly.rise;
		end else if (uf) begin
			ticks = dly.fall;
		end else begin
			ticks = dly.turnoff;
		end
		due = {1'b0, item.now} + {1'b0, ticks};

		state_nx = state;
		ovf      = 1'b0;
		res.commit = 1'b0;
		cm = state.pend_has_mask ? state.pend_mask : '1;

		if (item.mode == MODE_TICK) begin
			if (state.pend_valid && state.pend_time == item.now) begin
				state_nx.cur.bits = (state.cur.bits & ~cm) | (state.pend.bits & cm);
				state_nx.cur.x    = (state.cur.x & ~cm) | (state.pend.x & cm);
				state_nx.cur.z    = (state.cur.z & ~cm) | (state.pend.z & cm);
				state_nx.pend_valid = 1'b0;
				res.commit = 1'b1;
			end
		end else if (!pend_keep) begin
			// Cancel, then schedule unless the value already matches or the due time overflows.
			state_nx.pend_valid = 1'b0;
			if (diff != '0) begin
				if (due[TW]) begin
					ovf = 1'b1;
				end else begin
					state_nx.pend          = nv;
					state_nx.pend_mask     = item.use_mask ? m : '0;
					state_nx.pend_has_mask = item.use_mask;
					state_nx.pend_time     = due[TW-1:0];
					state_nx.pend_valid    = 1'b1;
				end
			end
		end

		res.value   = state_nx.cur;
		res.pending = state_nx.pend_valid;
		res.due     = state_nx.pend_valid ? state_nx.pend_time : '0;
		res.ovf     = ovf;
	end

endmodule
`default_nettype wire

>>> design/inertial_delay_scheduler_unit.sv
// Top level of the inertial delay scheduler: one four-state driver with rise/fall/turn-off delay.
//
//  channel | handshake              | word
//  --------+------------------------+--------------------------------------------------
//  in      | in_valid / in_ready    | mode, now, value_bits/x/z, use_mask, mask_enable
//  out     | out_valid / out_ready  | commit_valid, out_bits/x/z, pending_out, due_time,
//          |                        | overflow_error
//  cfg     | cfg_wr_en (no wait)    | cfg_index, cfg_data
//
// One word per cycle sustained while results are taken; the result is registered behind the input.
// An input register feeds the evaluation logic, which updates the driver state and
// loads the result register in the same cycle. The state loop (value, pending update)
// closes through the state register alone, so the next word sees it at once.
// Pairwise delay minima are registered from the delay registers after a configuration write.
// A stalled result holds the input register; a new word is still taken when the
// result register drains in that cycle. Reset puts the value at all X, nothing pending.
`default_nettype none
module inertial_delay_scheduler_unit
	import ids_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	// configuration
	input  wire logic          cfg_wr_en,
	input  wire logic [IW-1:0] cfg_index,
	input  wire logic [TW-1:0] cfg_data,
	// input channel
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          mode,
	input  wire logic [31:0]   now,
	input  wire logic [31:0]   value_bits,
	input  wire logic [31:0]   value_x,
	input  wire logic [31:0]   value_z,
	input  wire logic          use_mask,
	input  wire logic [31:0]   mask_enable,
	// output channel
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               commit_valid,
	output logic [31:0]        out_bits,
	output logic [31:0]        out_x,
	output logic [31:0]        out_z,
	output logic               pending_out,
	output logic [31:0]        due_time,
	output logic               overflow_error
);

	logic [TW-1:0] rise_q, fall_q, turnoff_q;
	logic [TW-1:0] min_rf_q, min_rt_q, min_ft_q, min_all_q;
	delay_t        dly;

	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nx;
	result_t res_nx;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q    <= '0;
			fall_q    <= '0;
			turnoff_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RISE:    rise_q    <= cfg_data;
				REG_FALL:    fall_q    <= cfg_data;
				REG_TURNOFF: turnoff_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Pre-reduce the delays so the schedule path is one select and one add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rf_q  <= '0;
			min_rt_q  <= '0;
			min_ft_q  <= '0;
			min_all_q <= '0;
		end else begin
			min_rf_q  <= (rise_q < fall_q) ? rise_q : fall_q;
			min_rt_q  <= (rise_q < turnoff_q) ? rise_q : turnoff_q;
			min_ft_q  <= (fall_q < turnoff_q) ? fall_q : turnoff_q;
			min_all_q <= (rise_q < fall_q) ? ((rise_q < turnoff_q) ? rise_q : turnoff_q)
				: ((fall_q < turnoff_q) ? fall_q : turnoff_q);
		end
	end

	assign dly = '{rise: rise_q, fall: fall_q, turnoff: turnoff_q, min_rf: min_rf_q,
		min_rt: min_rt_q, min_ft: min_ft_q, min_all: min_all_q};

	// Advance the input word when the result register is free or drains now.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input payload register; bits above the signal width are dropped here.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.mode        <= mode;
			item_s1.now         <= now;
			item_s1.value.bits  <= value_bits[VW-1:0];
			item_s1.value.x     <= value_x[VW-1:0];
			item_s1.value.z     <= value_z[VW-1:0];
			item_s1.use_mask    <= use_mask;
			item_s1.mask        <= mask_enable[VW-1:0];
		end
	end

	ids_eval u_eval (
		.item     (item_s1),
		.state    (state_q),
		.dly      (dly),
		.state_nx (state_nx),
		.res      (res_nx)
	);

	// Driver state: current value and the one pending update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cur.bits      <= '0;
			state_q.cur.x         <= '1;
			state_q.cur.z         <= '0;
			state_q.pend          <= '0;
			state_q.pend_mask     <= '0;
			state_q.pend_has_mask <= 1'b0;
			state_q.pend_time     <= '0;
			state_q.pend_valid    <= 1'b0;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nx;
		end
	end

	assign out_valid      = valid_s2;
	assign commit_valid   = res_s2.commit;
	assign out_bits       = 32'(res_s2.value.bits);
	assign out_x          = 32'(res_s2.value.x);
	assign out_z          = 32'(res_s2.value.z);
	assign pending_out    = res_s2.pending;
	assign due_time       = res_s2.due;
	assign overflow_error = res_s2.ovf;

endmodule
`default_nettype wire

>>> dv/tb_inertial_delay_scheduler_unit.sv
// Self-checking testbench for the inertial delay scheduler unit.
import ids_pkg::*;

// Scoreboard: keeps its own copy of the driver state, predicts one result per accepted word.
class commit_scoreboard;
	localparam logic [VW-1:0] WMASK = '1;

	logic [TW-1:0] rise_ticks, fall_ticks, turnoff_ticks;
	fsv_t          cur;
	fsv_t          pend;
	logic [VW-1:0] pend_mask;
	logic          pend_has_mask;
	logic [TW-1:0] pend_time;
	logic          pend_valid;

	result_t       due_results[$];
	int            errors, words, commits, overflows, kept, settings;

	function new();
		rise_ticks = '0;
		fall_ticks = '0;
		turnoff_ticks = '0;
		cur.bits = '0;
		cur.x = WMASK;
		cur.z = '0;
		clear_pending();
		errors = 0;
		words = 0;
		commits = 0;
		overflows = 0;
		kept = 0;
		settings = 1;
	endfunction

	function void clear_pending();
		pend = '0;
		pend_mask = '0;
		pend_has_mask = 1'b0;
		pend_time = '0;
		pend_valid = 1'b0;
	endfunction

	function bit same_value(fsv_t a, fsv_t b, logic [VW-1:0] m);
		return (((a.bits ^ b.bits) | (a.x ^ b.x) | (a.z ^ b.z)) & m) == '0;
	endfunction

	function void set_delays(logic [TW-1:0] r, logic [TW-1:0] f, logic [TW-1:0] t);
		rise_ticks = r;
		fall_ticks = f;
		turnoff_ticks = t;
		settings++;
	endfunction

	// Advance the state by one accepted word and queue the result it causes.
	function void note_word(item_t w);
		result_t       want;
		fsv_t          nv;
		logic [VW-1:0] m, diff, n0, msk;
		logic [TW-1:0] ticks, least;
		logic [TW:0]   sum;
		bit            found, ovf, commit;
		ovf = 1'b0;
		commit = 1'b0;
		words++;
		if (w.mode == MODE_ASSIGN) begin
			// X wins over Z, Z wins over the value plane
			nv.x = w.value.x & WMASK;
			nv.z = w.value.z & ~nv.x & WMASK;
			nv.bits = w.value.bits & ~nv.x & ~nv.z & WMASK;
			m = w.use_mask ? (w.mask & WMASK) : WMASK;
			if (pend_valid && pend_has_mask == w.use_mask &&
			    (!w.use_mask || pend_mask == m) && same_value(pend, nv, m)) begin
				kept++;
			end else begin
				if (pend_valid)
					clear_pending();
				if (!same_value(cur, nv, m)) begin
					diff = m & ((cur.bits ^ nv.bits) | (cur.x ^ nv.x) | (cur.z ^ nv.z));
					n0 = WMASK & ~nv.bits & ~nv.x & ~nv.z;
					least = (rise_ticks < fall_ticks) ? rise_ticks : fall_ticks;
					least = (least < turnoff_ticks) ? least : turnoff_ticks;
					found = 1'b0;
					ticks = '0;
					if ((diff & nv.bits) != '0) begin
						ticks = rise_ticks;
						found = 1'b1;
					end
					if ((diff & n0) != '0 && (!found || fall_ticks < ticks)) begin
						ticks = fall_ticks;
						found = 1'b1;
					end
					if ((diff & nv.z) != '0 && (!found || turnoff_ticks < ticks)) begin
						ticks = turnoff_ticks;
						found = 1'b1;
					end
					if ((diff & nv.x) != '0 && (!found || least < ticks)) begin
						ticks = least;
						found = 1'b1;
					end
					sum = {1'b0, w.now} + {1'b0, ticks};
					if (sum[TW]) begin
						ovf = 1'b1;
						overflows++;
					end else begin
						pend = nv;
						pend_mask = w.use_mask ? m : '0;
						pend_has_mask = w.use_mask;
						pend_time = sum[TW-1:0];
						pend_valid = 1'b1;
					end
				end
			end
		end else if (pend_valid && pend_time == w.now) begin
			msk = pend_has_mask ? pend_mask : WMASK;
			cur.bits = (cur.bits & ~msk) | (pend.bits & msk);
			cur.x = (cur.x & ~msk) | (pend.x & msk);
			cur.z = (cur.z & ~msk) | (pend.z & msk);
			clear_pending();
			commit = 1'b1;
			commits++;
		end
		want.commit = commit;
		want.value = cur;
		want.pending = pend_valid;
		want.due = pend_valid ? pend_time : '0;
		want.ovf = ovf;
		due_results.push_back(want);
	endfunction

	function void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %h, actual %h", name, want_v, got_v);
			errors++;
		end
	endfunction

	// Compare one result word against the oldest prediction.
	function void check_word(result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			$error("result word with no prediction waiting (commit_valid %0b)", got.commit);
			errors++;
			return;
		end
		want = due_results.pop_front();
		check_field("commit_valid", 32'(want.commit), 32'(got.commit));
		check_field("out_bits", 32'(want.value.bits), 32'(got.value.bits));
		check_field("out_x", 32'(want.value.x), 32'(got.value.x));
		check_field("out_z", 32'(want.value.z), 32'(got.value.z));
		check_field("pending_out", 32'(want.pending), 32'(got.pending));
		check_field("due_time", want.due, got.due);
		check_field("overflow_error", 32'(want.ovf), 32'(got.ovf));
	endfunction
endclass

module tb_inertial_delay_scheduler_unit;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 13;
	localparam int PHASE_WORDS = 142;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_wr_en;
	logic [IW-1:0] cfg_index;
	logic [TW-1:0] cfg_data;
	logic          in_valid;
	logic          in_ready;
	logic          mode;
	logic [31:0]   now;
	logic [31:0]   value_bits;
	logic [31:0]   value_x;
	logic [31:0]   value_z;
	logic          use_mask;
	logic [31:0]   mask_enable;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic          commit_valid;
	logic [31:0]   out_bits;
	logic [31:0]   out_x;
	logic [31:0]   out_z;
	logic          pending_out;
	logic [31:0]   due_time;
	logic          overflow_error;

	commit_scoreboard sb = new();

	// time base that assign words use for now; moves forward as the run goes
	logic [TW-1:0] t_base = '0;
	int            cycle_count = 0;
	int            rcv_cycle = 0;
	int            rcv_style = 0;

	inertial_delay_scheduler_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.now            (now),
		.value_bits     (value_bits),
		.value_x        (value_x),
		.value_z        (value_z),
		.use_mask       (use_mask),
		.mask_enable    (mask_enable),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.commit_valid   (commit_valid),
		.out_bits       (out_bits),
		.out_x          (out_x),
		.out_z          (out_z),
		.pending_out    (pending_out),
		.due_time       (due_time),
		.overflow_error (overflow_error)
	);

	always #5 clk = ~clk;

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: switch stall style at random over the run. Styles are
	// always ready, random, a fixed two-in-eight stall, and long stalls.
	always @(posedge clk) begin
		rcv_cycle <= rcv_cycle + 1;
		if (rcv_cycle % 300 == 0)
			rcv_style <= $urandom_range(0, 3);
		case (rcv_style)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 9) < 7);
			2: out_ready <= (rcv_cycle % 8 != 5) && (rcv_cycle % 8 != 6);
			default: out_ready <= (rcv_cycle % 9 == 0);
		endcase
	end

	// Monitor: sample the result word at the edge it is taken.
	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got.commit = commit_valid;
			got.value.bits = out_bits[VW-1:0];
			got.value.x = out_x[VW-1:0];
			got.value.z = out_z[VW-1:0];
			got.pending = pending_out;
			got.due = due_time;
			got.ovf = overflow_error;
			sb.check_word(got);
		end
	end

	function automatic item_t mk_word(logic m, logic [31:0] t, logic [31:0] b,
	                                  logic [31:0] x, logic [31:0] z,
	                                  logic um, logic [31:0] msk);
		item_t w;
		w.mode = m;
		w.now = t;
		w.value.bits = b[VW-1:0];
		w.value.x = x[VW-1:0];
		w.value.z = z[VW-1:0];
		w.use_mask = um;
		w.mask = msk[VW-1:0];
		return w;
	endfunction

	// Random four-state value: raw planes, sparse X/Z, a uniform level,
	// or the current value with one bit nudged.
	function automatic fsv_t rand_value();
		fsv_t          v;
		logic [VW-1:0] flip;
		case ($urandom_range(0, 4))
			0: begin
				v.bits = $urandom;
				v.x = $urandom;
				v.z = $urandom;
			end
			1, 4: begin
				v.bits = $urandom;
				v.x = $urandom & $urandom & $urandom;
				v.z = $urandom & $urandom & $urandom;
			end
			2: begin
				v = '0;
				case ($urandom_range(0, 3))
					0: v.bits = '0;
					1: v.bits = '1;
					2: v.z = '1;
					default: v.x = '1;
				endcase
			end
			default: begin
				flip = '0;
				flip[$urandom_range(0, VW-1)] = 1'b1;
				v = sb.cur;
				v.bits = v.bits ^ flip;
				v.x = v.x & ~flip;
				if ($urandom_range(0, 3) == 0)
					v.z = v.z ^ flip;
			end
		endcase
		return v;
	endfunction

	function automatic logic [VW-1:0] rand_mask();
		logic [VW-1:0] msk;
		case ($urandom_range(0, 4))
			0: msk = '0;
			1: msk = '1;
			2: msk = $urandom;
			3: begin
				msk = '0;
				msk[$urandom_range(0, VW-1)] = 1'b1;
			end
			default: msk = 32'h0000_FFFF;
		endcase
		return msk;
	endfunction

	// Next random word. Most ticks land on the pending time so updates
	// really commit; some assigns re-offer the pending or current value.
	function automatic item_t make_word();
		item_t w;
		int    pick;
		pick = $urandom_range(0, 99);
		w.mode = MODE_ASSIGN;
		w.now = t_base;
		w.value = rand_value();
		w.use_mask = ($urandom_range(0, 2) == 0);
		w.mask = rand_mask();
		if (pick < 8) begin
			// noise: every field random
			w.mode = 1'($urandom_range(0, 1));
			w.now = $urandom;
			w.value.bits = $urandom;
			w.value.x = $urandom;
			w.value.z = $urandom;
			w.use_mask = 1'($urandom_range(0, 1));
			w.mask = $urandom;
		end else if (pick < 53) begin
			w.mode = MODE_TICK;
			if (sb.pend_valid && $urandom_range(0, 99) < 70) begin
				w.now = sb.pend_time;
				if (sb.pend_time > t_base)
					t_base = sb.pend_time;
			end else if ($urandom_range(0, 1) == 1) begin
				w.now = t_base + 32'($urandom_range(0, 2));
			end else begin
				w.now = $urandom;
			end
		end else if (sb.pend_valid && pick < 63) begin
			w.value = sb.pend;
			w.use_mask = sb.pend_has_mask;
			if (sb.pend_has_mask)
				w.mask = sb.pend_mask;
		end else if (pick < 70) begin
			w.value = sb.cur;
		end
		t_base = t_base + 32'($urandom_range(0, 3));
		return w;
	endfunction

	// Present one word and hold it until taken; call at a clock edge.
	task automatic send_word(input item_t w);
		in_valid <= 1'b1;
		mode <= w.mode;
		now <= w.now;
		value_bits <= w.value.bits;
		value_x <= w.value.x;
		value_z <= w.value.z;
		use_mask <= w.use_mask;
		mask_enable <= w.mask;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(w);
	endtask

	task automatic stop_words();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain every prediction, then give the pipeline time to empty.
	task automatic settle();
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three delay registers back to back, then wait for the
	// registered minima to follow.
	task automatic load_delays(input logic [TW-1:0] r, input logic [TW-1:0] f,
	                           input logic [TW-1:0] t);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_RISE;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= REG_FALL;
		cfg_data <= f;
		@(posedge clk);
		cfg_index <= REG_TURNOFF;
		cfg_data <= t;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		repeat (3) @(posedge clk);
		sb.set_delays(r, f, t);
	endtask

	// Random words in bursts; some bursts run back to back with no gap.
	task automatic run_words(input int count);
		int burst;
		int gap;
		burst = $urandom_range(1, 16);
		for (int i = 0; i < count; i++) begin
			send_word(make_word());
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		stop_words();
	endtask

	task automatic run_phase(input int p);
		logic [TW-1:0] r, f, t;
		case (p % 7)
			0: begin
				r = $urandom_range(0, 15);
				f = $urandom_range(0, 15);
				t = $urandom_range(0, 15);
			end
			1: begin
				r = '0;
				f = '0;
				t = '0;
			end
			2: begin
				r = '1;
				f = '1;
				t = '1;
			end
			3: begin
				r = '1;
				f = $urandom_range(0, 7);
				t = $urandom_range(0, 7);
			end
			4: begin
				r = $urandom;
				f = $urandom;
				t = $urandom;
			end
			5: begin
				r = $urandom_range(1, 4);
				f = r;
				t = r;
			end
			default: begin
				r = $urandom_range(0, 3);
				f = '1;
				t = '0;
			end
		endcase
		load_delays(r, f, t);
		// push some phases up against the top of the time range
		if (p % 4 == 3)
			t_base = 32'hFFFF_FF00 + 32'($urandom_range(0, 200));
		else if (p % 7 == 2)
			t_base = '0;
		run_words(PHASE_WORDS);
		settle();
	endtask

	initial begin
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_RISE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= MODE_ASSIGN;
		now <= '0;
		value_bits <= '0;
		value_x <= '0;
		value_z <= '0;
		use_mask <= 1'b0;
		mask_enable <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset delays are all zero: an update falls due at the time it is made.
		send_word(mk_word(MODE_TICK, 0, $urandom, $urandom, $urandom, 1'b1, $urandom));
		send_word(mk_word(MODE_ASSIGN, 5, 0, 0, 0, 1'b0, 0));
		send_word(mk_word(MODE_TICK, 5, 0, 0, 0, 1'b0, 0));
		stop_words();
		settle();

		load_delays(3, 5, 7);
		// rise, then the same value again keeps the update; early tick misses
		send_word(mk_word(MODE_ASSIGN, 10, '1, 0, 0, 1'b0, 0));
		send_word(mk_word(MODE_ASSIGN, 11, '1, 0, 0, 1'b0, 0));
		send_word(mk_word(MODE_TICK, 12, 0, 0, 0, 1'b0, 0));
		send_word(mk_word(MODE_TICK, 13, 0, 0, 0, 1'b0, 0));
		// turn-off replaced by a fall before it is due
		send_word(mk_word(MODE_ASSIGN, 20, 0, 0, '1, 1'b0, 0));
		send_word(mk_word(MODE_ASSIGN, 21, 0, 0, 0, 1'b0, 0));
		send_word(mk_word(MODE_TICK, 26, 0, 0, 0, 1'b0, 0));
		// change to X; a late tick leaves it pending, then it is cancelled
		send_word(mk_word(MODE_ASSIGN, 30, 0, '1, 0, 1'b0, 0));
		send_word(mk_word(MODE_TICK, 40, 0, 0, 0, 1'b0, 0));
		send_word(mk_word(MODE_ASSIGN, 41, 0, 0, 0, 1'b0, 0));
		// mixed rise, Z and X bits take the least delay
		send_word(mk_word(MODE_ASSIGN, 50, 32'h0000_FFFF, 32'hF000_0000, 32'h00FF_0000,
		                  1'b0, 0));
		send_word(mk_word(MODE_TICK, 53, 0, 0, 0, 1'b0, 0));
		// empty mask, then masked updates kept and replaced
		send_word(mk_word(MODE_ASSIGN, 60, $urandom, $urandom, $urandom, 1'b1, 0));
		send_word(mk_word(MODE_ASSIGN, 60, 0, 0, 0, 1'b1, 32'h0000_00FF));
		send_word(mk_word(MODE_ASSIGN, 61, 32'hFFFF_FF00, 0, 0, 1'b1, 32'h0000_00FF));
		send_word(mk_word(MODE_ASSIGN, 62, 0, 0, 0, 1'b1, 32'h0000_FF00));
		send_word(mk_word(MODE_TICK, 67, 0, 0, 0, 1'b0, 0));
		// now plus delay past the top of the time range
		send_word(mk_word(MODE_ASSIGN, 32'hFFFF_FFFE, '1, 0, 0, 1'b0, 0));
		// all planes set: X wins
		send_word(mk_word(MODE_ASSIGN, 70, '1, '1, '1, 1'b1, '1));
		send_word(mk_word(MODE_TICK, 73, $urandom, $urandom, $urandom, 1'b1, $urandom));
		send_word(mk_word(MODE_TICK, '1, '1, '1, '1, 1'b1, '1));
		stop_words();
		settle();

		t_base = 32'd100;
		for (int p = 0; p < PHASES; p++)
			run_phase(p);

		settle();
		repeat (8) @(posedge clk);
		$display("Run covered %0d words over %0d delay settings: %0d commits, %0d overflows,",
		         sb.words, sb.settings, sb.commits, sb.overflows);
		$display("%0d pending updates kept, receiver stalls and sender gaps mixed in.", sb.kept);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
